[rtl/core/tcf_pkg.sv]
// Shared codes and constants for the telnet receive command filter.
package tcf_pkg;

  localparam logic [7:0] BYTE_IAC  = 8'hff;
  localparam logic [7:0] BYTE_DONT = 8'hfe;
  localparam logic [7:0] BYTE_DO   = 8'hfd;
  localparam logic [7:0] BYTE_WONT = 8'hfc;
  localparam logic [7:0] BYTE_WILL = 8'hfb;
  localparam logic [7:0] BYTE_SE   = 8'hf0;

  localparam logic [3:0] DATA_BITS_MAX   = 4'd8;
  localparam logic [3:0] DATA_BITS_RESET = 4'd8;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

endpackage

[rtl/core/telnet_receive_command_filter.sv]
// Telnet receive command filter: strips IAC sequences and answers option requests.
//
//   channel  dir  tdata              tuser      tlast
//   s_       in   [7:0] rx_byte      -          -
//   m_       out  [7:0] value        [1:0] kind last
//   cfg_     in   cfg_wdata[3:0] data bits per byte, written while cfg_we is high
//
// One input byte is taken per cycle; its results sit in a single output register.
// A byte causing one result or none never stalls the input stream.
// An option request yields a three-transfer reply (IAC, verb, option), holding the
// input while the reply drains from the output register.
// Reset (rst, synchronous) returns the parser to idle, word size to eight, output empty.
// Back-pressure on m_tready holds the output register and, through it, s_tready.
module telnet_receive_command_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,    // data bits per byte
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // [7:0] value
  output logic [1:0] m_tuser,      // [1:0] kind
  output logic       m_tlast
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CMD    = 2'd1,
    PH_OPTION = 2'd2
  } phase_t;

  phase_t        phase;
  tcf_pkg::verb_t verb;
  logic [3:0]    data_bits;

  logic          out_valid;
  logic [1:0]    out_kind;
  logic [7:0]    out_value;
  logic          out_last;
  logic [1:0]    rem;          // results still to follow the head
  logic [7:0]    reply_verb;
  logic [7:0]    reply_opt;

  logic [3:0]    ws_clamped;
  logic [7:0]    mask;
  logic [7:0]    b;
  logic          in_xfer;
  logic          out_xfer;

  always_comb begin
    ws_clamped = (data_bits > tcf_pkg::DATA_BITS_MAX) ? tcf_pkg::DATA_BITS_MAX : data_bits;
    mask       = 8'hff >> (tcf_pkg::DATA_BITS_MAX - ws_clamped);
    b          = s_tdata & mask;
  end

  assign out_xfer = out_valid && m_tready;
  assign s_tready = !out_valid || (m_tready && (rem == 2'd0));
  assign in_xfer  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= tcf_pkg::DATA_BITS_RESET;
      phase     <= PH_IDLE;
      verb      <= tcf_pkg::VERB_WILL;
      out_valid <= 1'b0;
      rem       <= 2'd0;
    end else begin
      if (cfg_we) begin
        data_bits <= cfg_wdata;
      end

      // drain the output register; an input transfer takes it over instead
      if (out_xfer && !in_xfer) begin
        unique case (rem)
          2'd2: begin
            out_value <= reply_verb;
            out_last  <= 1'b0;
            rem       <= 2'd1;
          end
          2'd1: begin
            out_value <= reply_opt;
            out_last  <= 1'b1;
            rem       <= 2'd0;
          end
          default: out_valid <= 1'b0;
        endcase
      end

      if (in_xfer) begin
        unique case (phase)
          PH_CMD: begin
            if (b == tcf_pkg::BYTE_IAC) begin
              phase     <= PH_IDLE;
              out_valid <= 1'b1;
              out_kind  <= tcf_pkg::KIND_DATA;
              out_value <= tcf_pkg::BYTE_IAC;
              out_last  <= 1'b1;
              rem       <= 2'd0;
            end else if (b < tcf_pkg::BYTE_SE) begin
              phase     <= PH_IDLE;
              out_valid <= 1'b1;
              out_kind  <= tcf_pkg::KIND_ERROR;
              out_value <= b;
              out_last  <= 1'b1;
              rem       <= 2'd0;
            end else if (b >= tcf_pkg::BYTE_WILL) begin
              verb      <= tcf_pkg::verb_t'(b[1:0] - tcf_pkg::BYTE_WILL[1:0]);
              phase     <= PH_OPTION;
              out_valid <= 1'b0;
            end else begin
              phase     <= PH_IDLE;
              out_valid <= 1'b0;
            end
          end
          PH_OPTION: begin
            phase <= PH_IDLE;
            if (verb == tcf_pkg::VERB_WILL || verb == tcf_pkg::VERB_DO) begin
              out_valid  <= 1'b1;
              out_kind   <= tcf_pkg::KIND_REPLY;
              out_value  <= tcf_pkg::BYTE_IAC;
              out_last   <= 1'b0;
              rem        <= 2'd2;
              reply_verb <= (verb == tcf_pkg::VERB_WILL) ? tcf_pkg::BYTE_DONT
                                                          : tcf_pkg::BYTE_WONT;
              reply_opt  <= b;
            end else begin
              out_valid  <= 1'b0;
            end
          end
          default: begin
            if (b == tcf_pkg::BYTE_IAC) begin
              phase     <= PH_CMD;
              out_valid <= 1'b0;
            end else begin
              phase     <= PH_IDLE;
              out_valid <= 1'b1;
              out_kind  <= tcf_pkg::KIND_DATA;
              out_value <= b;
              out_last  <= 1'b1;
              rem       <= 2'd0;
            end
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_needs_valid: assert property (@(posedge clk) disable iff (rst)
    (rem != 2'd0) |-> out_valid)
    else $error("reply results pending with empty output register");

  a_rem_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rem != 2'd0) |-> !m_tlast)
    else $error("last flag set before reply is complete");

  a_reply_verb: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && rem == 2'd2) |=>
      (m_tuser == tcf_pkg::KIND_REPLY &&
       (m_tdata == tcf_pkg::BYTE_DONT || m_tdata == tcf_pkg::BYTE_WONT)))
    else $error("second reply transfer is not a refusal verb");

  a_verb_to_option: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && phase == PH_CMD && b >= tcf_pkg::BYTE_WILL && b != tcf_pkg::BYTE_IAC)
      |=> (phase == PH_OPTION))
    else $error("negotiation verb did not move parser to option phase");
`endif

endmodule
